// File: hw/rtl/strided_convolution_2d_unit_macros.svh
// Assertion macros used by the strided convolution top level.
`ifndef STRIDED_CONVOLUTION_2D_UNIT_MACROS_SVH
`define STRIDED_CONVOLUTION_2D_UNIT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define SCONV_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, gated off during reset.
`define SCONV_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// File: hw/rtl/sconv_pkg.sv
// Shared types, constants and helpers of the strided convolution unit.
`default_nettype none
package sconv_pkg;
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_KERNEL_DEF = 8;
   localparam int PIXEL_BITS_DEF = 16;

   localparam int DATA_W      = 16;
   localparam int COEF_IDX_W  = 6;
   localparam int OUT_W       = 37;
   localparam int IDX_W       = 16;
   localparam int ROW_W       = 12;
   localparam int WIDTH_REG_W = 9;
   localparam int HEIGHT_W    = 13;
   localparam int HEIGHT_MAX  = 4096;
   localparam int KREG_W      = 4;
   localparam int STRIDE_W    = 4;
   localparam int STRIDE_MAX  = 8;
   localparam int PHASE_W     = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [2:0] {
      REG_IMG_WIDTH  = 3'd0,
      REG_IMG_HEIGHT = 3'd1,
      REG_KERN_H     = 3'd2,
      REG_KERN_W     = 3'd3,
      REG_STRIDE     = 3'd4
   } csr_reg_type;

   typedef enum logic {
      REQ_COEF  = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   // Result bookkeeping that travels beside the sum.
   typedef struct packed {
      logic             last;
      logic [IDX_W-1:0] index;
   } tag_type;

   function automatic int slot_bits(int mk);
      return (mk > 1) ? $clog2(mk) : 1;
   endfunction

   function automatic int coef_bits(int mk);
      return (mk > 1) ? $clog2(mk * mk) : 1;
   endfunction

   function automatic int sum_bits(int pw, int mk);
      return 2 * pw + 2 * slot_bits(mk) + 2;
   endfunction

   // Advance a stride phase, wrapping at the stride.
   function automatic logic [PHASE_W-1:0] next_phase(logic [PHASE_W-1:0] ph,
                                                     logic [STRIDE_W-1:0] s);
      if (STRIDE_W'(ph) + STRIDE_W'(1) == s) begin
         return '0;
      end
      return ph + PHASE_W'(1);
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/sconv_lbuf.sv
// Line memory and window shift register of the strided convolution unit.
`default_nettype none
module sconv_lbuf #(
   parameter int MAX_WIDTH  = sconv_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL = sconv_pkg::MAX_KERNEL_DEF,
   parameter int PIX_W      = sconv_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          en,
   input  wire logic                                          wr_valid,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]                  wr_col,
   input  wire logic [sconv_pkg::slot_bits(MAX_KERNEL)-1:0]   wr_slot,
   input  wire logic [PIX_W-1:0]                              wr_val,
   output logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0]   window
);
   localparam int SB = sconv_pkg::slot_bits(MAX_KERNEL);

   // One word per column, one lane per row slot.
   logic [MAX_KERNEL-1:0][PIX_W-1:0] mem [MAX_WIDTH];
   logic [MAX_KERNEL-1:0][PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0]                 val_ff;
   logic [SB-1:0]                    slot_ff;
   logic                             pix_ff;
   logic [MAX_KERNEL-1:0][PIX_W-1:0] column;
   logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem[wr_col][wr_slot] <= wr_val;
      end
      if (en) begin
         rd_ff   <= mem[wr_col];
         val_ff  <= wr_val;
         slot_ff <= wr_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= 1'b0;
      end else if (en) begin
         pix_ff <= wr_valid;
      end
   end

   // Replace the stale lane with the pixel just written.
   always_comb begin
      for (int s = 0; s < MAX_KERNEL; s++) begin
         column[s] = (SB'(s) == slot_ff) ? val_ff : rd_ff[s];
      end
   end

   // Shift the newest column in at position zero.
   always_ff @(posedge clock) begin
      if (en && pix_ff) begin
         window_ff[0] <= column;
         for (int k = 1; k < MAX_KERNEL; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   assign window = window_ff;
endmodule
`default_nettype wire

// File: hw/rtl/sconv_dot.sv
// Product lanes and registered adder tree of the strided convolution unit.
`default_nettype none
module sconv_dot #(
   parameter int MAX_KERNEL = sconv_pkg::MAX_KERNEL_DEF,
   parameter int PIX_W      = sconv_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                                                clock,
   input  wire logic                                                reset,
   input  wire logic                                                en,
   input  wire logic                                                in_valid,
   input  wire sconv_pkg::tag_type                                  in_tag,
   input  wire logic [sconv_pkg::slot_bits(MAX_KERNEL)-1:0]         base,
   input  wire logic [$clog2(MAX_KERNEL+1)-1:0]                     kern_h,
   input  wire logic [$clog2(MAX_KERNEL+1)-1:0]                     kern_w,
   input  wire logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0]    window,
   input  wire logic [MAX_KERNEL*MAX_KERNEL-1:0][PIX_W-1:0]         coef,
   output logic                                                     out_valid,
   output sconv_pkg::tag_type                                       out_tag,
   output logic signed [sconv_pkg::sum_bits(PIX_W, MAX_KERNEL)-1:0] out_sum
);
   localparam int SB = sconv_pkg::slot_bits(MAX_KERNEL);
   localparam int CI = sconv_pkg::coef_bits(MAX_KERNEL);
   localparam int PW2 = 2 * PIX_W;
   localparam int RW = PW2 + SB + 1;
   localparam int SW = sconv_pkg::sum_bits(PIX_W, MAX_KERNEL);

   logic signed [PW2-1:0] prod_in [MAX_KERNEL][MAX_KERNEL];
   logic signed [PW2-1:0] prod_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [RW-1:0]  row_in  [MAX_KERNEL];
   logic signed [RW-1:0]  row_ff  [MAX_KERNEL];
   logic signed [SW-1:0]  sum_in;
   logic signed [SW-1:0]  sum_ff;
   logic                  s3_valid_ff, s4_valid_ff, s5_valid_ff;
   sconv_pkg::tag_type    s3_tag_ff, s4_tag_ff, s5_tag_ff;

   // Pick each lane's pixel and coefficient; lanes outside the kernel add zero.
   always_comb begin
      int ofs;
      int rsl;
      int ci;
      logic signed [PIX_W-1:0] pa;
      logic signed [PIX_W-1:0] pb;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int j = 0; j < MAX_KERNEL; j++) begin
            ofs = 32'(kern_w) - 1 - j;
            rsl = 32'(base) + i;
            if (rsl >= MAX_KERNEL) begin
               rsl = rsl - MAX_KERNEL;
            end
            ci = i * 32'(kern_w) + j;
            if (i < 32'(kern_h) && j < 32'(kern_w)) begin
               pa = $signed(window[ofs[SB-1:0]][rsl[SB-1:0]]);
               pb = $signed(coef[ci[CI-1:0]]);
            end else begin
               pa = '0;
               pb = '0;
            end
            prod_in[i][j] = PW2'(pa) * PW2'(pb);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < MAX_KERNEL; j++) begin
            row_in[i] = row_in[i] + RW'(prod_ff[i][j]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         sum_in = sum_in + SW'(row_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         row_ff    <= row_in;
         sum_ff    <= sum_in;
         s3_tag_ff <= in_tag;
         s4_tag_ff <= s3_tag_ff;
         s5_tag_ff <= s4_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_tag   = s5_tag_ff;
   assign out_sum   = sum_ff;
endmodule
`default_nettype wire

// File: hw/rtl/strided_convolution_2d_unit.sv
// Top level of the strided 2D convolution unit (valid mode, line-buffered).
`default_nettype none
`include "strided_convolution_2d_unit_macros.svh"
// Streams an image in raster order and returns one sum of products for every
// kernel window that closes on the stride grid, with its row-major output
// index and a last flag on the final window of the frame. A coefficient item
// (req_type 0) loads one kernel entry in row-major order and restarts the
// frame; a CSR write to a configuration register restarts it too. Pixels and
// coefficients are Q8.8, the sum keeps full precision, saturated to 37 bits
// as Q21.16. Throughput is one item per cycle while rsp is not stalled: each
// pixel costs one write and one read of the column-organized line memory, and
// all kernel products run in parallel lanes. The result passes the memory
// read registered at the accepting edge, then window shift, product, row sums,
// total and output register. Input is stalled only while the output register
// holds a result that the consumer stalls. There is no clearing pass after
// reset; load every coefficient in use before streaming pixels.
module strided_convolution_2d_unit #(
   parameter int MAX_WIDTH  = sconv_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL = sconv_pkg::MAX_KERNEL_DEF,
   parameter int PIXEL_BITS = sconv_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // item input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_type,
   input  wire logic [sconv_pkg::COEF_IDX_W-1:0]      req_coef_index,
   input  wire logic signed [sconv_pkg::DATA_W-1:0]   req_data_value,
   // result output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [sconv_pkg::OUT_W-1:0]         rsp_conv_value,
   output logic [sconv_pkg::IDX_W-1:0]                rsp_out_index,
   output logic                                       rsp_last_result,
   // configuration
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [sconv_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [sconv_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sconv_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                       csr_pready
);
   localparam int PW = (PIXEL_BITS < sconv_pkg::DATA_W) ? PIXEL_BITS : sconv_pkg::DATA_W;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int KB = $clog2(MAX_KERNEL + 1);
   localparam int SB = sconv_pkg::slot_bits(MAX_KERNEL);
   localparam int CI = sconv_pkg::coef_bits(MAX_KERNEL);
   localparam int SW = sconv_pkg::sum_bits(PW, MAX_KERNEL);
   localparam int OW = sconv_pkg::OUT_W;
   localparam int EW = (SW > OW) ? SW : OW;
   localparam logic signed [EW-1:0] SAT_MAX = (EW'(1) <<< (OW - 1)) - EW'(1);
   localparam logic signed [EW-1:0] SAT_MIN = -(EW'(1) <<< (OW - 1));
   localparam int HW = sconv_pkg::HEIGHT_W;
   localparam int PH = sconv_pkg::PHASE_W;

   // configuration registers, held clamped
   logic [WW-1:0]                   img_width_ff, img_width_in;
   logic [HW-1:0]                   img_height_ff, img_height_in;
   logic [KB-1:0]                   kern_h_ff, kern_h_in;
   logic [KB-1:0]                   kern_w_ff, kern_w_in;
   logic [sconv_pkg::STRIDE_W-1:0]  stride_ff, stride_in;
   logic                            cfg_wr;
   logic                            cfg_hit;
   sconv_pkg::csr_reg_type          cfg_sel;

   // frame position
   logic [sconv_pkg::ROW_W-1:0]     row_pos_ff, row_pos_in;
   logic [CW-1:0]                   col_pos_ff, col_pos_in;
   logic [sconv_pkg::IDX_W-1:0]     out_count_ff, out_count_in;
   logic [SB-1:0]                   slot_ff, slot_in;
   logic [PH-1:0]                   row_ph_ff, row_ph_in;
   logic [PH-1:0]                   col_ph_ff, col_ph_in;

   // accept-stage decode
   logic                            advance;
   logic                            pix_acc, coef_acc, coef_ok;
   logic [sconv_pkg::ROW_W-1:0]     er;
   logic [CW-1:0]                   ec;
   logic [sconv_pkg::IDX_W-1:0]     ecnt, cnt_next;
   logic [SB-1:0]                   eslot, base;
   logic [PH-1:0]                   erph, ecph;
   logic                            row_in_win, col_in_win, emit, last;
   logic [PW-1:0]                   pix_val;

   // pipeline stages ahead of the product lanes
   logic                            s1_coef_ff, s1_emit_ff, s2_coef_ff, s2_emit_ff;
   sconv_pkg::tag_type              s1_tag_ff, s2_tag_ff;
   logic [SB-1:0]                   s1_base_ff, s2_base_ff;
   logic [CI-1:0]                   s1_cidx_ff, s2_cidx_ff;
   logic [PW-1:0]                   s1_cval_ff, s2_cval_ff;
   logic [MAX_KERNEL*MAX_KERNEL-1:0][PW-1:0] coef_ff;

   logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PW-1:0] window;
   logic                            dot_valid;
   sconv_pkg::tag_type              dot_tag;
   logic signed [SW-1:0]            dot_sum;
   logic signed [EW-1:0]            sum_ext;
   logic signed [OW-1:0]            sat_val;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]            rsp_conv_value_ff;
   logic [sconv_pkg::IDX_W-1:0]     rsp_out_index_ff;
   logic                            rsp_last_result_ff;

   // The whole pipeline moves together; only a held result stops it.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign pix_acc   = req_valid && advance && (req_type == sconv_pkg::REQ_PIXEL);
   assign coef_acc  = req_valid && advance && (req_type == sconv_pkg::REQ_COEF);
   assign coef_ok   = 32'(req_coef_index) < MAX_KERNEL * MAX_KERNEL;
   assign pix_val   = req_data_value[PW-1:0];

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_sel    = sconv_pkg::csr_reg_type'(csr_paddr[sconv_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      kern_h_in     = kern_h_ff;
      kern_w_in     = kern_w_ff;
      stride_in     = stride_ff;
      cfg_hit       = 1'b0;
      if (cfg_wr) begin
         case (cfg_sel)
            sconv_pkg::REG_IMG_WIDTH: begin
               cfg_hit = 1'b1;
               if (csr_pwdata[sconv_pkg::WIDTH_REG_W-1:0] == '0) begin
                  img_width_in = WW'(1);
               end else if (32'(csr_pwdata[sconv_pkg::WIDTH_REG_W-1:0]) > MAX_WIDTH) begin
                  img_width_in = WW'(MAX_WIDTH);
               end else begin
                  img_width_in = WW'(csr_pwdata[sconv_pkg::WIDTH_REG_W-1:0]);
               end
            end
            sconv_pkg::REG_IMG_HEIGHT: begin
               cfg_hit = 1'b1;
               if (csr_pwdata[HW-1:0] == '0) begin
                  img_height_in = HW'(1);
               end else if (32'(csr_pwdata[HW-1:0]) > sconv_pkg::HEIGHT_MAX) begin
                  img_height_in = HW'(sconv_pkg::HEIGHT_MAX);
               end else begin
                  img_height_in = csr_pwdata[HW-1:0];
               end
            end
            sconv_pkg::REG_KERN_H: begin
               cfg_hit = 1'b1;
               if (csr_pwdata[sconv_pkg::KREG_W-1:0] == '0) begin
                  kern_h_in = KB'(1);
               end else if (32'(csr_pwdata[sconv_pkg::KREG_W-1:0]) > MAX_KERNEL) begin
                  kern_h_in = KB'(MAX_KERNEL);
               end else begin
                  kern_h_in = KB'(csr_pwdata[sconv_pkg::KREG_W-1:0]);
               end
            end
            sconv_pkg::REG_KERN_W: begin
               cfg_hit = 1'b1;
               if (csr_pwdata[sconv_pkg::KREG_W-1:0] == '0) begin
                  kern_w_in = KB'(1);
               end else if (32'(csr_pwdata[sconv_pkg::KREG_W-1:0]) > MAX_KERNEL) begin
                  kern_w_in = KB'(MAX_KERNEL);
               end else begin
                  kern_w_in = KB'(csr_pwdata[sconv_pkg::KREG_W-1:0]);
               end
            end
            sconv_pkg::REG_STRIDE: begin
               cfg_hit = 1'b1;
               if (csr_pwdata[sconv_pkg::STRIDE_W-1:0] == '0) begin
                  stride_in = sconv_pkg::STRIDE_W'(1);
               end else if (32'(csr_pwdata[sconv_pkg::STRIDE_W-1:0]) >
                            sconv_pkg::STRIDE_MAX) begin
                  stride_in = sconv_pkg::STRIDE_W'(sconv_pkg::STRIDE_MAX);
               end else begin
                  stride_in = csr_pwdata[sconv_pkg::STRIDE_W-1:0];
               end
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_sel)
         sconv_pkg::REG_IMG_WIDTH:  csr_prdata = 32'(img_width_ff);
         sconv_pkg::REG_IMG_HEIGHT: csr_prdata = 32'(img_height_ff);
         sconv_pkg::REG_KERN_H:     csr_prdata = 32'(kern_h_ff);
         sconv_pkg::REG_KERN_W:     csr_prdata = 32'(kern_w_ff);
         sconv_pkg::REG_STRIDE:     csr_prdata = 32'(stride_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= WW'(MAX_WIDTH);
         img_height_ff <= HW'(256);
         kern_h_ff     <= KB'((MAX_KERNEL < 3) ? MAX_KERNEL : 3);
         kern_w_ff     <= KB'((MAX_KERNEL < 3) ? MAX_KERNEL : 3);
         stride_ff     <= sconv_pkg::STRIDE_W'(1);
      end else begin
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         kern_h_ff     <= kern_h_in;
         kern_w_ff     <= kern_w_in;
         stride_ff     <= stride_in;
      end
   end

   // ---------------- accept stage: position and window decode ----------------
   always_comb begin
      // A position left outside a shrunk frame restarts at the origin.
      if ((32'(row_pos_ff) >= 32'(img_height_ff)) || (32'(col_pos_ff) >= 32'(img_width_ff))) begin
         er    = '0;
         ec    = '0;
         ecnt  = '0;
         eslot = '0;
         erph  = '0;
         ecph  = '0;
      end else begin
         er    = row_pos_ff;
         ec    = col_pos_ff;
         ecnt  = out_count_ff;
         eslot = slot_ff;
         erph  = row_ph_ff;
         ecph  = col_ph_ff;
      end

      row_in_win = 32'(er) + 1 >= 32'(kern_h_ff);
      col_in_win = 32'(ec) + 1 >= 32'(kern_w_ff);
      emit = (32'(kern_h_ff) <= 32'(img_height_ff)) && (32'(kern_w_ff) <= 32'(img_width_ff)) &&
             row_in_win && col_in_win && (erph == '0) && (ecph == '0);
      // No further grid position fits right of or below this window.
      last = (32'(er) + 1 + 32'(stride_ff) > 32'(img_height_ff)) &&
             (32'(ec) + 1 + 32'(stride_ff) > 32'(img_width_ff));
      cnt_next = emit ? ecnt + sconv_pkg::IDX_W'(1) : ecnt;

      // Slot of the window's top row in the circular line memory.
      if (32'(eslot) >= 32'(kern_h_ff) - 1) begin
         base = SB'(32'(eslot) - (32'(kern_h_ff) - 1));
      end else begin
         base = SB'(32'(eslot) + MAX_KERNEL - (32'(kern_h_ff) - 1));
      end

      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      out_count_in = out_count_ff;
      slot_in      = slot_ff;
      row_ph_in    = row_ph_ff;
      col_ph_in    = col_ph_ff;

      if (cfg_hit || coef_acc) begin
         row_pos_in   = '0;
         col_pos_in   = '0;
         out_count_in = '0;
         slot_in      = '0;
         row_ph_in    = '0;
         col_ph_in    = '0;
      end else if (pix_acc) begin
         row_pos_in   = er;
         out_count_in = cnt_next;
         slot_in      = eslot;
         row_ph_in    = erph;
         if (32'(ec) + 1 >= 32'(img_width_ff)) begin
            col_pos_in = '0;
            col_ph_in  = '0;
            if (32'(er) + 1 >= 32'(img_height_ff)) begin
               row_pos_in   = '0;
               out_count_in = '0;
               slot_in      = '0;
               row_ph_in    = '0;
            end else begin
               row_pos_in = er + sconv_pkg::ROW_W'(1);
               slot_in    = (eslot == SB'(MAX_KERNEL - 1)) ? '0 : eslot + SB'(1);
               row_ph_in  = row_in_win ? sconv_pkg::next_phase(erph, stride_ff) : '0;
            end
         end else begin
            col_pos_in = ec + CW'(1);
            col_ph_in  = col_in_win ? sconv_pkg::next_phase(ecph, stride_ff) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         out_count_ff <= '0;
         slot_ff      <= '0;
         row_ph_ff    <= '0;
         col_ph_ff    <= '0;
      end else begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         out_count_ff <= out_count_in;
         slot_ff      <= slot_in;
         row_ph_ff    <= row_ph_in;
         col_ph_ff    <= col_ph_in;
      end
   end

   // ---------------- line memory and window ----------------
   sconv_lbuf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL),
      .PIX_W      (PW)
   ) u_lbuf (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .wr_valid (pix_acc),
      .wr_col   (ec),
      .wr_slot  (eslot),
      .wr_val   (pix_val),
      .window   (window)
   );

   // ---------------- stages 1 and 2: carry tags, delay coefficient writes ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff  <= '{last: last, index: ecnt};
         s1_base_ff <= base;
         s1_cidx_ff <= CI'(req_coef_index);
         s1_cval_ff <= pix_val;
         s2_tag_ff  <= s1_tag_ff;
         s2_base_ff <= s1_base_ff;
         s2_cidx_ff <= s1_cidx_ff;
         s2_cval_ff <= s1_cval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_coef_ff <= 1'b0;
         s1_emit_ff <= 1'b0;
         s2_coef_ff <= 1'b0;
         s2_emit_ff <= 1'b0;
      end else if (advance) begin
         s1_coef_ff <= coef_acc && coef_ok;
         s1_emit_ff <= pix_acc && emit;
         s2_coef_ff <= s1_coef_ff;
         s2_emit_ff <= s1_emit_ff;
      end
   end

   // Write the kernel in item order: pixels ahead of a load still see the old entry.
   always_ff @(posedge clock) begin
      if (advance && s2_coef_ff) begin
         coef_ff[s2_cidx_ff] <= s2_cval_ff;
      end
   end

   // ---------------- products and adder tree ----------------
   sconv_dot #(
      .MAX_KERNEL (MAX_KERNEL),
      .PIX_W      (PW)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s2_emit_ff),
      .in_tag    (s2_tag_ff),
      .base      (s2_base_ff),
      .kern_h    (kern_h_ff),
      .kern_w    (kern_w_ff),
      .window    (window),
      .coef      (coef_ff),
      .out_valid (dot_valid),
      .out_tag   (dot_tag),
      .out_sum   (dot_sum)
   );

   // ---------------- saturate and hold the result ----------------
   always_comb begin
      sum_ext = EW'(dot_sum);
      if (sum_ext > SAT_MAX) begin
         sat_val = OW'(SAT_MAX);
      end else if (sum_ext < SAT_MIN) begin
         sat_val = OW'(SAT_MIN);
      end else begin
         sat_val = OW'(sum_ext);
      end
      rsp_valid_in = advance ? dot_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_conv_value_ff  <= sat_val;
         rsp_out_index_ff   <= dot_tag.index;
         rsp_last_result_ff <= dot_tag.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_conv_value  = rsp_conv_value_ff;
   assign rsp_out_index   = rsp_out_index_ff;
   assign rsp_last_result = rsp_last_result_ff;

   // ---------------- assertions ----------------
   `SCONV_ASSERT_NOW(a_held_result_stalls_input, clock, reset,
      rsp_valid_ff && rsp_stall, req_stall, "input taken while result is held")
   `SCONV_ASSERT_NEXT(a_tree_result_lands, clock, reset,
      dot_valid && advance, rsp_valid_ff, "finished sum lost before output register")
   `SCONV_ASSERT_NEXT(a_coef_restarts_frame, clock, reset,
      coef_acc, (row_pos_ff == '0) && (col_pos_ff == '0) && (out_count_ff == '0),
      "coefficient load did not restart the frame")
endmodule
`default_nettype wire
